>>> rtl/gqwd_pkg.sv
// Shared types, constants and helpers for the grouped quantized weight dot product.
`timescale 1ns / 1ps

package gqwd_pkg;

    localparam int NUM_LANES = 6;
    localparam int FMT_W     = 2;
    localparam int CNT_W     = 3;
    localparam int WORD_W    = 24;
    localparam int ACT_W     = 16;
    localparam int CODE_W    = 8;
    localparam int PROD_W    = CODE_W + ACT_W;
    localparam int COEF_W    = 24;
    localparam int GSUM_W    = 32;
    localparam int ASUM_W    = 25;
    localparam int LSUM_W    = PROD_W + 3;
    localparam int LASUM_W   = ACT_W + 3;
    localparam int P1_W      = COEF_W + GSUM_W;
    localparam int P2_W      = COEF_W + ASUM_W;
    localparam int Q_W       = P1_W + 1;
    localparam int TOTAL_W   = 64;
    localparam int EXT_W     = TOTAL_W + 1;

    // weight formats
    localparam logic [FMT_W-1:0] FMT_BYTE    = 2'd0;
    localparam logic [FMT_W-1:0] FMT_NIB     = 2'd1;
    localparam logic [FMT_W-1:0] FMT_NIB_MIN = 2'd2;
    localparam logic [FMT_W-1:0] FMT_SIX     = 2'd3;

    // request kinds
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    localparam logic [CNT_W-1:0] CAP_BYTE = 3'd3;
    localparam logic [CNT_W-1:0] CAP_NIB  = 3'd6;
    localparam logic [CNT_W-1:0] CAP_SIX  = 3'd4;

    localparam logic [3:0] NIB_MASK = 4'hF;
    localparam logic [5:0] SIX_MASK = 6'h3F;
    localparam logic signed [CODE_W-1:0] NIB_OFFSET = 8'sd8;
    localparam logic signed [CODE_W-1:0] SIX_OFFSET = 8'sd32;

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic                     valid;
        logic                     emit;
        logic                     use_min;
        logic signed [GSUM_W-1:0] gsum;
        logic signed [ASUM_W-1:0] asum;
        logic signed [COEF_W-1:0] scale;
        logic signed [COEF_W-1:0] minimum;
    } flush_t;

    function automatic logic [CNT_W-1:0] lane_capacity(input logic [FMT_W-1:0] fmt);
        logic [CNT_W-1:0] cap;
        unique case (fmt)
            FMT_BYTE:    cap = CAP_BYTE;
            FMT_NIB:     cap = CAP_NIB;
            FMT_NIB_MIN: cap = CAP_NIB;
            FMT_SIX:     cap = CAP_SIX;
            default:     cap = CAP_NIB;
        endcase
        return cap;
    endfunction

endpackage

>>> rtl/grouped_quant_weight_dot.sv
// Top level: grouped quantized weight row dot product with six parallel lanes.
`timescale 1ns / 1ps

// Usage:
//   Configure weight_format through cfg_wr_en / cfg_wr_data while no request is in flight.
//   The s_ channel carries header requests (s_opcode = 0: scale and minimum of the next
//   group) and weight requests (s_opcode = 1: packed word, six activations, count, row end).
//   A request is taken when s_valid and s_ready are both high; one request per cycle.
//   Six lanes decode and multiply one code each, a merge stage folds them into the group
//   sums, and each group end is scaled and added into a saturating 64-bit row total.
//   The weight request with s_row_end = 1 produces one result on the m_ channel:
//   m_dot_value (32 fraction bits) and m_saturated. Headers never produce a result.
//   The row's last request passes the lane, merge, multiply and prepare registers and the
//   result register before m_valid rises; one request per cycle while s_ready is high.
//   The result sits in an output register; requests keep flowing while it waits, and
//   s_ready drops only when a second result reaches the end of the pipe with the first
//   one still untaken. Synchronous active-low reset clears the format to signed byte,
//   all sums, the held scale and minimum, and empties the pipeline.
module grouped_quant_weight_dot (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [gqwd_pkg::FMT_W-1:0]            cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic signed [gqwd_pkg::COEF_W-1:0]    s_group_scale,
    input  logic signed [gqwd_pkg::COEF_W-1:0]    s_group_minimum,
    input  logic [gqwd_pkg::WORD_W-1:0]           s_weight_word,
    input  logic signed [gqwd_pkg::ACT_W-1:0]     s_act_zero,
    input  logic signed [gqwd_pkg::ACT_W-1:0]     s_act_one,
    input  logic signed [gqwd_pkg::ACT_W-1:0]     s_act_two,
    input  logic signed [gqwd_pkg::ACT_W-1:0]     s_act_three,
    input  logic signed [gqwd_pkg::ACT_W-1:0]     s_act_four,
    input  logic signed [gqwd_pkg::ACT_W-1:0]     s_act_five,
    input  logic [gqwd_pkg::CNT_W-1:0]            s_valid_count,
    input  logic                                  s_row_end,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [gqwd_pkg::TOTAL_W-1:0]   m_dot_value,
    output logic                                  m_saturated
);
    import gqwd_pkg::*;

    logic [FMT_W-1:0]          format_reg;
    logic                      s1_valid_reg;
    logic                      s1_opcode_reg;
    logic                      s1_row_end_reg;
    logic [FMT_W-1:0]          s1_fmt_reg;
    logic signed [COEF_W-1:0]  s1_scale_reg;
    logic signed [COEF_W-1:0]  s1_min_reg;
    logic signed [ACT_W-1:0]   act_in [NUM_LANES];
    logic signed [PROD_W-1:0]  lane_prod [NUM_LANES];
    logic signed [ACT_W-1:0]   lane_act [NUM_LANES];
    flush_t                    flush;
    logic                      emit_head;
    logic                      adv;

    // hold the pipeline only while a finished row is blocked behind an untaken result
    assign adv     = !(emit_head && m_valid && !m_ready);
    assign s_ready = adv;

    assign act_in[0] = s_act_zero;
    assign act_in[1] = s_act_one;
    assign act_in[2] = s_act_two;
    assign act_in[3] = s_act_three;
    assign act_in[4] = s_act_four;
    assign act_in[5] = s_act_five;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg   <= FMT_BYTE;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                format_reg <= cfg_wr_data;
            end
            if (adv) begin
                s1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_opcode_reg  <= s_opcode;
            s1_row_end_reg <= s_row_end;
            s1_fmt_reg     <= format_reg;
            s1_scale_reg   <= s_group_scale;
            s1_min_reg     <= s_group_minimum;
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        gqwd_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .aclk          (aclk),
            .en            (adv),
            .weight_format (format_reg),
            .weight_word   (s_weight_word),
            .valid_count   (s_valid_count),
            .act           (act_in[i]),
            .prod_reg      (lane_prod[i]),
            .act_reg       (lane_act[i])
        );
    end

    gqwd_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in_valid      (s1_valid_reg),
        .opcode        (s1_opcode_reg),
        .row_end       (s1_row_end_reg),
        .weight_format (s1_fmt_reg),
        .group_scale   (s1_scale_reg),
        .group_minimum (s1_min_reg),
        .prod          (lane_prod),
        .act           (lane_act),
        .flush_reg     (flush)
    );

    gqwd_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .flush_in    (flush),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_dot_value (m_dot_value),
        .m_saturated (m_saturated),
        .emit_head   (emit_head)
    );

endmodule

>>> rtl/gqwd_lane.sv
// One decode-and-multiply lane: extracts its weight code and registers code times activation.
`timescale 1ns / 1ps

module gqwd_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [gqwd_pkg::FMT_W-1:0]            weight_format,
    input  logic [gqwd_pkg::WORD_W-1:0]           weight_word,
    input  logic [gqwd_pkg::CNT_W-1:0]            valid_count,
    input  logic signed [gqwd_pkg::ACT_W-1:0]     act,
    output logic signed [gqwd_pkg::PROD_W-1:0]    prod_reg,
    output logic signed [gqwd_pkg::ACT_W-1:0]     act_reg
);
    import gqwd_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(LANE_IDX);

    logic [2*WORD_W-1:0]        word_wide;
    logic [CODE_W-1:0]          byte_f;
    logic [3:0]                 nib_f;
    logic [5:0]                 six_f;
    logic [CNT_W-1:0]           cap;
    logic [CNT_W-1:0]           used;
    logic                       active;
    logic signed [CODE_W-1:0]   code;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACT_W-1:0]    act_next;

    // zero-pad so every lane's field select stays in range
    assign word_wide = {{WORD_W{1'b0}}, weight_word};
    assign byte_f    = word_wide[8*LANE_IDX +: 8];
    assign nib_f     = word_wide[4*LANE_IDX +: 4] & NIB_MASK;
    assign six_f     = word_wide[6*LANE_IDX +: 6] & SIX_MASK;

    always_comb begin
        cap    = lane_capacity(weight_format);
        used   = (valid_count > cap) ? cap : valid_count;
        active = (IDX < used);
        unique case (weight_format)
            FMT_BYTE:    code = $signed(byte_f);
            FMT_NIB:     code = $signed({4'b0000, nib_f}) - NIB_OFFSET;
            FMT_NIB_MIN: code = $signed({4'b0000, nib_f});
            FMT_SIX:     code = $signed({2'b00, six_f}) - SIX_OFFSET;
            default:     code = '0;
        endcase
        // keep the multiply in its own signed context
        prod_full = code * act;
        prod_next = active ? prod_full : '0;
        act_next  = active ? act : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            act_reg  <= act_next;
        end
    end

endmodule

>>> rtl/gqwd_merge.sv
// Merge stage: sums the lane results into the group sums and issues group flushes.
`timescale 1ns / 1ps

module gqwd_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic                                opcode,
    input  logic                                row_end,
    input  logic [gqwd_pkg::FMT_W-1:0]          weight_format,
    input  logic signed [gqwd_pkg::COEF_W-1:0]  group_scale,
    input  logic signed [gqwd_pkg::COEF_W-1:0]  group_minimum,
    input  logic signed [gqwd_pkg::PROD_W-1:0]  prod [gqwd_pkg::NUM_LANES],
    input  logic signed [gqwd_pkg::ACT_W-1:0]   act [gqwd_pkg::NUM_LANES],
    output gqwd_pkg::flush_t                    flush_reg
);
    import gqwd_pkg::*;

    logic signed [GSUM_W-1:0]  group_sum_reg, group_sum_next;
    logic signed [ASUM_W-1:0]  act_sum_reg, act_sum_next;
    logic signed [COEF_W-1:0]  held_scale_reg, held_scale_next;
    logic signed [COEF_W-1:0]  held_min_reg, held_min_next;
    flush_t                    flush_next;
    logic signed [LSUM_W-1:0]  lane_sum;
    logic signed [LASUM_W-1:0] lane_asum;
    logic signed [GSUM_W-1:0]  gsum_add;
    logic signed [ASUM_W-1:0]  asum_add;

    always_comb begin
        lane_sum  = '0;
        lane_asum = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_sum  = lane_sum + LSUM_W'(prod[i]);
            lane_asum = lane_asum + LASUM_W'(act[i]);
        end
        // both sums wrap at their register widths
        gsum_add = group_sum_reg + GSUM_W'(lane_sum);
        asum_add = act_sum_reg + ASUM_W'(lane_asum);
    end

    always_comb begin
        group_sum_next     = group_sum_reg;
        act_sum_next       = act_sum_reg;
        held_scale_next    = held_scale_reg;
        held_min_next      = held_min_reg;
        flush_next         = '0;
        flush_next.scale   = held_scale_reg;
        flush_next.minimum = held_min_reg;
        flush_next.use_min = (weight_format == FMT_NIB_MIN);
        if (in_valid) begin
            if (opcode == OP_HEADER) begin
                // close the running group with the old coefficients, then load new ones
                flush_next.valid = 1'b1;
                flush_next.gsum  = group_sum_reg;
                flush_next.asum  = act_sum_reg;
                group_sum_next   = '0;
                act_sum_next     = '0;
                held_scale_next  = group_scale;
                held_min_next    = group_minimum;
            end else if (row_end) begin
                flush_next.valid = 1'b1;
                flush_next.emit  = 1'b1;
                flush_next.gsum  = gsum_add;
                flush_next.asum  = asum_add;
                group_sum_next   = '0;
                act_sum_next     = '0;
            end else begin
                group_sum_next   = gsum_add;
                act_sum_next     = asum_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_sum_reg  <= '0;
            act_sum_reg    <= '0;
            held_scale_reg <= '0;
            held_min_reg   <= '0;
            flush_reg      <= '0;
        end else if (en) begin
            group_sum_reg  <= group_sum_next;
            act_sum_reg    <= act_sum_next;
            held_scale_reg <= held_scale_next;
            held_min_reg   <= held_min_next;
            flush_reg      <= flush_next;
        end
    end

`ifndef SYNTH
    a_header_clears_group: assert property (@(posedge aclk) disable iff (!aresetn)
        en && in_valid && (opcode == OP_HEADER) |=> (group_sum_reg == '0) && (act_sum_reg == '0))
        else $error("group sums not cleared after header");
`endif

endmodule

>>> rtl/gqwd_accum.sv
// Flush pipeline: scales group sums, saturating row accumulation and result register.
`timescale 1ns / 1ps

module gqwd_accum (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  gqwd_pkg::flush_t                     flush_in,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic signed [gqwd_pkg::TOTAL_W-1:0]  m_dot_value,
    output logic                                 m_saturated,
    output logic                                 emit_head
);
    import gqwd_pkg::*;

    // multiply stage
    logic                      s3_valid_reg, s3_emit_reg;
    logic signed [P1_W-1:0]    p1_reg, p1_next;
    logic signed [P2_W-1:0]    p2_reg, p2_next;
    logic signed [P2_W-1:0]    p2_full;

    // prepare stage
    logic                      s4_valid_reg, s4_emit_reg;
    logic signed [P1_W-1:0]    p1b_reg;
    logic signed [Q_W-1:0]     q_reg, q_next;
    logic signed [TOTAL_W-1:0] hi_sat_reg, hi_sat_next;
    logic signed [TOTAL_W-1:0] lo_sat_reg, lo_sat_next;

    // accumulate stage
    logic signed [TOTAL_W-1:0] row_total_reg, row_total_next;
    logic                      clamp_reg, clamp_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [TOTAL_W-1:0] m_dot_value_reg, m_dot_value_next;
    logic                      m_saturated_reg, m_saturated_next;

    logic signed [EXT_W-1:0]   first_sum;
    logic signed [EXT_W-1:0]   both_sum;
    logic                      ovf_first, ovf_both, clamp_now;
    logic signed [TOTAL_W-1:0] total_new;
    logic                      fire;

    always_comb begin
        p1_next = flush_in.scale * flush_in.gsum;
        p2_full = flush_in.minimum * flush_in.asum;
        p2_next = flush_in.use_min ? p2_full : '0;
    end

    // outcomes of the minimum term when the scale term already clamped
    always_comb begin
        q_next      = Q_W'(p1_reg) + Q_W'(p2_reg);
        hi_sat_next = (!p2_reg[P2_W-1] && (p2_reg != '0)) ? TOTAL_MAX
                                                           : TOTAL_MAX + TOTAL_W'(p2_reg);
        lo_sat_next = p2_reg[P2_W-1] ? TOTAL_MIN : TOTAL_MIN + TOTAL_W'(p2_reg);
    end

    always_comb begin
        first_sum = EXT_W'(row_total_reg) + EXT_W'(p1b_reg);
        both_sum  = EXT_W'(row_total_reg) + EXT_W'(q_reg);
        ovf_first = first_sum[EXT_W-1] ^ first_sum[EXT_W-2];
        ovf_both  = !ovf_first && (both_sum[EXT_W-1] ^ both_sum[EXT_W-2]);
        clamp_now = ovf_first | ovf_both;
        if (ovf_first) begin
            total_new = first_sum[EXT_W-1] ? lo_sat_reg : hi_sat_reg;
        end else if (ovf_both) begin
            total_new = both_sum[EXT_W-1] ? TOTAL_MIN : TOTAL_MAX;
        end else begin
            total_new = both_sum[TOTAL_W-1:0];
        end
    end

    assign fire      = en && s4_valid_reg;
    assign emit_head = s4_valid_reg && s4_emit_reg;

    always_comb begin
        row_total_next   = row_total_reg;
        clamp_next       = clamp_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_dot_value_next = m_dot_value_reg;
        m_saturated_next = m_saturated_reg;
        if (fire) begin
            if (s4_emit_reg) begin
                // hand the total out and start a fresh row
                m_valid_next     = 1'b1;
                m_dot_value_next = total_new;
                m_saturated_next = clamp_reg | clamp_now;
                row_total_next   = '0;
                clamp_next       = 1'b0;
            end else begin
                row_total_next   = total_new;
                clamp_next       = clamp_reg | clamp_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg  <= 1'b0;
            s3_emit_reg   <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s4_emit_reg   <= 1'b0;
            row_total_reg <= '0;
            clamp_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (en) begin
                s3_valid_reg <= flush_in.valid;
                s3_emit_reg  <= flush_in.emit;
                s4_valid_reg <= s3_valid_reg;
                s4_emit_reg  <= s3_emit_reg;
            end
            row_total_reg <= row_total_next;
            clamp_reg     <= clamp_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            p1b_reg    <= p1_reg;
            q_reg      <= q_next;
            hi_sat_reg <= hi_sat_next;
            lo_sat_reg <= lo_sat_next;
        end
        m_dot_value_reg <= m_dot_value_next;
        m_saturated_reg <= m_saturated_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_dot_value = m_dot_value_reg;
    assign m_saturated = m_saturated_reg;

`ifndef SYNTH
    a_emit_clears_row: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && s4_emit_reg |=> (row_total_reg == '0) && !clamp_reg)
        else $error("row state not cleared after result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_head && m_valid_reg && !m_ready |-> !en)
        else $error("pipeline advanced over a held result");
`endif

endmodule
